// ----- src/ist_pkg.sv -----
package ist_pkg;

  // table geometry
  localparam int SLOTS  = 64;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int ID_W   = 16;
  localparam int POS_W  = 7;
  localparam int ST_W   = 2;
  localparam int ACT_W  = 2;

  // request actions
  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_SEARCH = 2'd2,
    ACT_LIST   = 2'd3
  } action_e;

  // result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_ZERO     = 2'd3
  } status_e;

  // control sequencer
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_OUT
  } state_e;

  // one result word
  typedef struct packed {
    status_e           status;
    logic [POS_W-1:0]  pos;
    logic [ID_W-1:0]   id;
  } result_t;

endpackage

// ----- src/ist_ram.sv -----
module ist_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ----- src/id_slot_table_unit.sv -----
// Table of 64 identifier slots held in one synchronous RAM, with a zero
// entry meaning a free slot. A request (add, delete, search or list) is
// served by walking the RAM one slot per cycle from slot 0 (a list walk
// can pause, see below); add, delete and search stop at the first
// matching slot, and a zero identifier on add, delete or search is
// rejected without a walk. The single read port of the slot RAM sets the
// walk pace. A list request emits one word per occupied slot and its walk
// pauses while the output stage is held by out_stall_i; every final word
// also waits there for as long as out_stall_i holds it. The table reads as
// all free after reset through per-slot valid flags, so no clearing pass
// is needed. One request is worked on at a time; in_stall_o is high from
// acceptance until the final word is loaded into the output stage.
module id_slot_table_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [ist_pkg::ACT_W-1:0] action_i,
  input  logic [ist_pkg::ID_W-1:0]  item_id_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [ist_pkg::ST_W-1:0]  status_o,
  output logic [ist_pkg::POS_W-1:0] position_o,
  output logic [ist_pkg::ID_W-1:0]  found_id_o,
  output logic                      last_o
);
  import ist_pkg::*;

  state_e              state_q, state_d;
  action_e             act_q;
  logic [ID_W-1:0]     id_q;
  logic [SLOT_W:0]     rd_idx_q, rd_idx_d;
  logic [SLOT_W-1:0]   chk_idx_q, chk_idx_d;
  logic                chk_v_q, chk_v_d;
  logic [SLOTS-1:0]    vld_q;
  logic                pend_v_q;
  logic [POS_W-1:0]    pend_pos_q;
  logic [ID_W-1:0]     pend_id_q;
  result_t             res_q, res_d;
  logic                out_vld_q;
  result_t             out_q;
  logic                out_last_q;

  logic                accept;
  logic [SLOT_W-1:0]   raddr;
  logic [ID_W-1:0]     rd_data;
  logic [ID_W-1:0]     entry;
  logic [ID_W-1:0]     target;
  logic                occupied, hit, is_list, end_slot;
  logic                out_free, walk_stall, step, term, push, pend_load, out_load;
  logic                ram_we, vld_set, vld_clr;
  logic [POS_W-1:0]    chk_pos;

  assign accept   = in_valid_i && !in_stall_o;
  assign out_free = !out_vld_q || !out_stall_i;
  assign is_list  = (act_q == ACT_LIST);

  // slot data as seen by the walk: never-written slots read as free
  assign entry    = vld_q[chk_idx_q] ? rd_data : '0;
  assign target   = (act_q == ACT_ADD) ? '0 : id_q;
  assign occupied = (entry != '0);
  assign hit      = (entry == target);
  assign end_slot = (chk_idx_q == SLOT_W'(SLOTS - 1));
  assign chk_pos  = POS_W'(chk_idx_q) + POS_W'(1);

  // list walk holds when a finished word cannot leave
  assign walk_stall = (state_q == S_WALK) && chk_v_q && is_list && occupied &&
                      pend_v_q && !out_free;
  assign step       = (state_q == S_WALK) && !walk_stall;
  assign term       = step && chk_v_q && (end_slot || (!is_list && hit));
  assign pend_load  = step && chk_v_q && is_list && occupied;
  assign push       = pend_load && pend_v_q;
  assign out_load   = (state_q == S_OUT) && out_free;

  // re-read the slot under check while stalled
  assign raddr = walk_stall ? chk_idx_q : rd_idx_q[SLOT_W-1:0];

  ist_ram #(
    .WIDTH (ID_W),
    .DEPTH (SLOTS)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (chk_idx_q),
    .wdata_i (id_q),
    .raddr_i (raddr),
    .rdata_o (rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (action_e'(action_i) != ACT_LIST && item_id_i == '0) begin
            state_d = S_OUT;
          end else begin
            state_d = S_WALK;
          end
        end
      end
      S_WALK: begin
        if (term) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // walk control, store updates and final result
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    rd_idx_d   = rd_idx_q;
    chk_idx_d  = chk_idx_q;
    chk_v_d    = chk_v_q;
    res_d      = res_q;
    ram_we     = 1'b0;
    vld_set    = 1'b0;
    vld_clr    = 1'b0;

    if (accept) begin
      rd_idx_d = '0;
      chk_v_d  = 1'b0;
      res_d    = '{status: ST_ZERO, pos: '0, id: '0};
    end

    if (step) begin
      chk_v_d   = (rd_idx_q < (SLOT_W + 1)'(SLOTS));
      chk_idx_d = rd_idx_q[SLOT_W-1:0];
      if (rd_idx_q < (SLOT_W + 1)'(SLOTS)) begin
        rd_idx_d = rd_idx_q + 1'b1;
      end
    end

    if (term) begin
      chk_v_d = 1'b0;
      if (is_list) begin
        if (occupied) begin
          res_d = '{status: ST_OK, pos: chk_pos, id: entry};
        end else if (pend_v_q) begin
          res_d = '{status: ST_OK, pos: pend_pos_q, id: pend_id_q};
        end else begin
          res_d = '{status: ST_NOTFOUND, pos: '0, id: '0};
        end
      end else if (hit) begin
        res_d = '{status: ST_OK, pos: chk_pos, id: id_q};
        if (act_q == ACT_ADD) begin
          ram_we  = 1'b1;
          vld_set = 1'b1;
        end else if (act_q == ACT_DELETE) begin
          vld_clr = 1'b1;
        end
      end else if (act_q == ACT_ADD) begin
        res_d = '{status: ST_FULL, pos: '0, id: '0};
      end else begin
        res_d = '{status: ST_NOTFOUND, pos: '0, id: '0};
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      chk_v_q   <= 1'b0;
      vld_q     <= '0;
      pend_v_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      chk_v_q <= chk_v_d;
      if (vld_set) begin
        vld_q[chk_idx_q] <= 1'b1;
      end else if (vld_clr) begin
        vld_q[chk_idx_q] <= 1'b0;
      end
      if (accept) begin
        pend_v_q <= 1'b0;
      end else if (pend_load) begin
        pend_v_q <= 1'b1;
      end
      if (push || out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    chk_idx_q <= chk_idx_d;
    res_q     <= res_d;
    if (accept) begin
      act_q <= action_e'(action_i);
      id_q  <= item_id_i;
    end
    if (pend_load) begin
      pend_pos_q <= chk_pos;
      pend_id_q  <= entry;
    end
    // output word: a pending list entry, or the final result
    if (push) begin
      out_q      <= '{status: ST_OK, pos: pend_pos_q, id: pend_id_q};
      out_last_q <= 1'b0;
    end else if (out_load) begin
      out_q      <= res_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_vld_q;
  assign status_o    = out_q.status;
  assign position_o  = out_q.pos;
  assign found_id_o  = out_q.id;
  assign last_o      = out_last_q;

endmodule
